// ===== hw/rtl/tcsr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcsr_pkg
// shared types, codes and defaults of the two-class rescue scheduler
// ----------------------------------------------------------------------------
package tcsr_pkg;

   localparam int ID_BITS_DEF     = 10;
   localparam int QUEUE_DEPTH_DEF = 256;
   localparam int MAX_BATCH_DEF   = 64;

   localparam int EVENT_W    = 10;
   localparam int MAXEV_W    = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int INTERVAL_W = 16;
   localparam int QUOTA_W    = 7;
   localparam int WORD_W     = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RESCUE_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESCUE_QUOTA    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAIN_TTL        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLDOWN_TICKS  = 2'd3;

   localparam logic [INTERVAL_W-1:0] RESCUE_INTERVAL_RST = 16'd4;
   localparam logic [QUOTA_W-1:0]    RESCUE_QUOTA_RST    = 7'd1;
   localparam logic [WORD_W-1:0]     MAIN_TTL_RST        = 32'd1000;
   localparam logic [WORD_W-1:0]     COOLDOWN_TICKS_RST  = 32'd100;

   // request operations and queue classes
   localparam logic OP_ENQUEUE  = 1'b0;
   localparam logic OP_SCHEDULE = 1'b1;
   localparam logic CLASS_FAST  = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_EVENT  = 2'd1;
   localparam logic [1:0] KIND_NONE   = 2'd2;

   // enqueue status codes
   localparam logic [1:0] ST_ACCEPTED  = 2'd0;
   localparam logic [1:0] ST_DUPLICATE = 2'd1;
   localparam logic [1:0] ST_COOLDOWN  = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic               op;
      logic [EVENT_W-1:0] evt_id;
      logic               queue_class;
      logic [MAXEV_W-1:0] batch_max;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         enqueue_status;
      logic [EVENT_W-1:0] out_event_id;
      logic               from_main;
      logic               last;
      logic [WORD_W-1:0]  fast_emitted_total;
      logic [WORD_W-1:0]  main_emitted_total;
      logic [WORD_W-1:0]  main_expired_total;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ENQ,
      S_EXP_RD,
      S_EXP_CHK,
      S_DECIDE,
      S_FAST_RD,
      S_FAST_POP,
      S_RESC_CHK,
      S_MAIN_RD,
      S_MAIN_POP,
      S_FINISH,
      S_EMIT_RD,
      S_EMIT_LOAD,
      S_EMIT_HOLD
   } state_type;

endpackage

// ===== hw/rtl/tcsr_ram.sv =====
// ----------------------------------------------------------------------------
// tcsr_ram
// simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tcsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/tcsr_id_table.sv =====
// ----------------------------------------------------------------------------
// tcsr_id_table
// per-id queued bit and cooldown deadline, swept to zero after reset
// ----------------------------------------------------------------------------
module tcsr_id_table #(
   parameter int ID_BITS = tcsr_pkg::ID_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   output logic                      busy,
   input  logic                      rd_en,
   input  logic [ID_BITS-1:0]        rd_addr,
   output logic                      rd_queued,
   output logic [tcsr_pkg::WORD_W-1:0] rd_cooldown,
   input  logic                      q_we,
   input  logic [ID_BITS-1:0]        q_addr,
   input  logic                      q_data,
   input  logic                      cd_we,
   input  logic [ID_BITS-1:0]        cd_addr,
   input  logic [tcsr_pkg::WORD_W-1:0] cd_data
);

   localparam int ENTRIES = 1 << ID_BITS;

   logic                        queued_ff [ENTRIES];
   logic [tcsr_pkg::WORD_W-1:0] cool_ff   [ENTRIES];
   logic                        busy_ff;
   logic [ID_BITS-1:0]          clr_ff;

   assign busy = busy_ff;

   // clearing sweep, one entry a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
      end else if (busy_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == {ID_BITS{1'b1}}) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         queued_ff[clr_ff] <= 1'b0;
         cool_ff[clr_ff]   <= '0;
      end else begin
         if (q_we) begin
            queued_ff[q_addr] <= q_data;
         end
         if (cd_we) begin
            cool_ff[cd_addr] <= cd_data;
         end
      end
      if (rd_en) begin
         rd_queued   <= queued_ff[rd_addr];
         rd_cooldown <= cool_ff[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/two_class_starvation_rescue_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// two_class_starvation_rescue_scheduler_unit
// strict-priority fast/main scheduler with starvation rescue and main ttl
//
//   channel | dir | handshake              | payload
//   req     | in  | req_valid / req_stall  | tcsr_pkg::req_type
//   rsp     | out | rsp_valid / rsp_stall  | tcsr_pkg::rsp_type
//   csr     | in  | csr_we                 | csr_index, csr_wdata
//
// one request at a time; an enqueue result is offered in S_EMIT_HOLD, which
// follows S_ENQ, and the unit returns to S_IDLE after its hand-off
// a round takes one memory read then one pop per expired or dispatched entry,
// plus overhead states such as decide and finish, then a read, a load and a
// hold per result read back from the result buffer, or a read and a hold for
// the single none result; after reset the id table sweeps all 2**ID_BITS
// entries, req_stall stays high meanwhile; csr writes are taken at any time
// results wait in an output register while rsp_stall is high
// ----------------------------------------------------------------------------
module two_class_starvation_rescue_scheduler_unit #(
   parameter int ID_BITS     = tcsr_pkg::ID_BITS_DEF,
   parameter int QUEUE_DEPTH = tcsr_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_BATCH   = tcsr_pkg::MAX_BATCH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  tcsr_pkg::req_type                  req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tcsr_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_we,
   input  logic [tcsr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tcsr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int W      = tcsr_pkg::WORD_W;
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int N_W    = $clog2(MAX_BATCH + 1);
   localparam int BUF_AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
   localparam int MAIN_W = ID_BITS + W;
   localparam int BUF_W  = ID_BITS + 1;

   // configuration
   logic [tcsr_pkg::INTERVAL_W-1:0] interval_ff;
   logic [tcsr_pkg::QUOTA_W-1:0]    quota_ff;
   logic [W-1:0]                    ttl_ff;
   logic [W-1:0]                    cdt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= tcsr_pkg::RESCUE_INTERVAL_RST;
         quota_ff    <= tcsr_pkg::RESCUE_QUOTA_RST;
         ttl_ff      <= tcsr_pkg::MAIN_TTL_RST;
         cdt_ff      <= tcsr_pkg::COOLDOWN_TICKS_RST;
      end else if (csr_we) begin
         case (csr_index)
            tcsr_pkg::CSR_RESCUE_INTERVAL: interval_ff <= csr_wdata[tcsr_pkg::INTERVAL_W-1:0];
            tcsr_pkg::CSR_RESCUE_QUOTA:    quota_ff    <= csr_wdata[tcsr_pkg::QUOTA_W-1:0];
            tcsr_pkg::CSR_MAIN_TTL:        ttl_ff      <= csr_wdata;
            tcsr_pkg::CSR_COOLDOWN_TICKS:  cdt_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer and datapath state
   tcsr_pkg::state_type state_ff, state_in;

   logic [W-1:0]         tick_ff, tick_in;
   logic [W-1:0]         streak_ff, streak_in;
   logic [W-1:0]         fast_tot_ff, fast_tot_in;
   logic [W-1:0]         main_tot_ff, main_tot_in;
   logic [W-1:0]         exp_tot_ff, exp_tot_in;
   logic [PTR_W-1:0]     fhead_ff, fhead_in, ftail_ff, ftail_in;
   logic [PTR_W-1:0]     mhead_ff, mhead_in, mtail_ff, mtail_in;
   logic [CNT_W-1:0]     fcnt_ff, fcnt_in, mcnt_ff, mcnt_in;
   logic [N_W-1:0]       limit_ff, limit_in;
   logic [N_W-1:0]       n_ff, n_in;
   logic [N_W-1:0]       k_ff, k_in;
   logic [N_W-1:0]       rescued_ff, rescued_in;
   logic                 rescue_ff, rescue_in;
   logic [ID_BITS-1:0]   enq_id_ff, enq_id_in;
   logic                 enq_fast_ff, enq_fast_in;

   // output register
   logic [1:0]                    o_kind_ff, o_kind_in;
   logic [1:0]                    o_status_ff, o_status_in;
   logic [tcsr_pkg::EVENT_W-1:0]  o_id_ff, o_id_in;
   logic                          o_main_ff, o_main_in;
   logic                          o_last_ff, o_last_in;

   // memory ports
   logic                 fram_we, fram_re;
   logic [ID_BITS-1:0]   fram_rdata;
   logic                 mram_we, mram_re;
   logic [MAIN_W-1:0]    mram_wdata, mram_rdata;
   logic                 bram_we, bram_re;
   logic [BUF_W-1:0]     bram_wdata, bram_rdata;
   logic                 tbl_busy, tbl_re;
   logic [ID_BITS-1:0]   tbl_raddr;
   logic                 tbl_queued;
   logic [W-1:0]         tbl_cool;
   logic                 q_we, q_data, cd_we;
   logic [ID_BITS-1:0]   q_addr, cd_addr;
   logic [W-1:0]         cd_data;

   // decoded request
   logic [ID_BITS-1:0]   req_id;
   logic [N_W-1:0]       req_limit;
   assign req_id    = ID_BITS'(req_payload.evt_id);
   assign req_limit = (req_payload.batch_max > tcsr_pkg::MAXEV_W'(MAX_BATCH))
                      ? N_W'(MAX_BATCH) : N_W'(req_payload.batch_max);

   // head entry views
   logic [ID_BITS-1:0]   mhead_id;
   logic [W-1:0]         mhead_tick;
   assign mhead_id   = mram_rdata[ID_BITS-1:0];
   assign mhead_tick = mram_rdata[MAIN_W-1:ID_BITS];

   // round decisions
   logic exp_hit, fast_go, main_go, resc_go, emit_last;
   assign exp_hit   = (tick_ff - mhead_tick) > ttl_ff;
   assign fast_go   = (fcnt_ff != '0) && (n_ff < limit_ff);
   assign main_go   = (mcnt_ff != '0) && (n_ff < limit_ff)
                      && (!rescue_ff || (tcsr_pkg::QUOTA_W'(rescued_ff) < quota_ff));
   assign resc_go   = (streak_ff >= W'(interval_ff)) && (mcnt_ff != '0);
   assign emit_last = ((k_ff + 1'b1) == n_ff);

   // enqueue verdict from the id table read
   logic [1:0] enq_status;
   always_comb begin
      if (tbl_queued) begin
         enq_status = tcsr_pkg::ST_DUPLICATE;
      end else if (!enq_fast_ff && (tbl_cool > tick_ff)) begin
         enq_status = tcsr_pkg::ST_COOLDOWN;
      end else if (enq_fast_ff ? (fcnt_ff == CNT_W'(QUEUE_DEPTH))
                               : (mcnt_ff == CNT_W'(QUEUE_DEPTH))) begin
         enq_status = tcsr_pkg::ST_FULL;
      end else begin
         enq_status = tcsr_pkg::ST_ACCEPTED;
      end
   end

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcsr_pkg::S_IDLE: begin
            if (req_valid && !tbl_busy) begin
               state_in = (req_payload.op == tcsr_pkg::OP_ENQUEUE)
                          ? tcsr_pkg::S_ENQ : tcsr_pkg::S_EXP_RD;
            end
         end
         tcsr_pkg::S_ENQ:       state_in = tcsr_pkg::S_EMIT_HOLD;
         tcsr_pkg::S_EXP_RD:    state_in = (mcnt_ff != '0) ? tcsr_pkg::S_EXP_CHK
                                                           : tcsr_pkg::S_DECIDE;
         tcsr_pkg::S_EXP_CHK:   state_in = exp_hit ? tcsr_pkg::S_EXP_RD : tcsr_pkg::S_DECIDE;
         tcsr_pkg::S_DECIDE:    state_in = (fcnt_ff != '0) ? tcsr_pkg::S_FAST_RD
                                                           : tcsr_pkg::S_MAIN_RD;
         tcsr_pkg::S_FAST_RD:   state_in = fast_go ? tcsr_pkg::S_FAST_POP
                                                   : tcsr_pkg::S_RESC_CHK;
         tcsr_pkg::S_FAST_POP:  state_in = tcsr_pkg::S_FAST_RD;
         tcsr_pkg::S_RESC_CHK:  state_in = resc_go ? tcsr_pkg::S_MAIN_RD : tcsr_pkg::S_FINISH;
         tcsr_pkg::S_MAIN_RD:   state_in = main_go ? tcsr_pkg::S_MAIN_POP : tcsr_pkg::S_FINISH;
         tcsr_pkg::S_MAIN_POP:  state_in = tcsr_pkg::S_MAIN_RD;
         tcsr_pkg::S_FINISH:    state_in = tcsr_pkg::S_EMIT_RD;
         tcsr_pkg::S_EMIT_RD:   state_in = (n_ff == '0) ? tcsr_pkg::S_EMIT_HOLD
                                                        : tcsr_pkg::S_EMIT_LOAD;
         tcsr_pkg::S_EMIT_LOAD: state_in = tcsr_pkg::S_EMIT_HOLD;
         tcsr_pkg::S_EMIT_HOLD: begin
            if (!rsp_stall) begin
               state_in = o_last_ff ? tcsr_pkg::S_IDLE : tcsr_pkg::S_EMIT_RD;
            end
         end
         default:               state_in = tcsr_pkg::S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      tick_in     = tick_ff;
      streak_in   = streak_ff;
      fast_tot_in = fast_tot_ff;
      main_tot_in = main_tot_ff;
      exp_tot_in  = exp_tot_ff;
      fhead_in    = fhead_ff;
      ftail_in    = ftail_ff;
      mhead_in    = mhead_ff;
      mtail_in    = mtail_ff;
      fcnt_in     = fcnt_ff;
      mcnt_in     = mcnt_ff;
      limit_in    = limit_ff;
      n_in        = n_ff;
      k_in        = k_ff;
      rescued_in  = rescued_ff;
      rescue_in   = rescue_ff;
      enq_id_in   = enq_id_ff;
      enq_fast_in = enq_fast_ff;
      o_kind_in   = o_kind_ff;
      o_status_in = o_status_ff;
      o_id_in     = o_id_ff;
      o_main_in   = o_main_ff;
      o_last_in   = o_last_ff;
      fram_we     = 1'b0;
      fram_re     = 1'b0;
      mram_we     = 1'b0;
      mram_re     = 1'b0;
      mram_wdata  = {tick_ff, enq_id_ff};
      bram_we     = 1'b0;
      bram_re     = 1'b0;
      bram_wdata  = {1'b0, fram_rdata};
      tbl_re      = 1'b0;
      tbl_raddr   = req_id;
      q_we        = 1'b0;
      q_addr      = fram_rdata;
      q_data      = 1'b0;
      cd_we       = 1'b0;
      cd_addr     = mhead_id;
      cd_data     = tick_ff + cdt_ff;
      case (state_ff)
         tcsr_pkg::S_IDLE: begin
            if (req_valid && !tbl_busy) begin
               enq_id_in   = req_id;
               enq_fast_in = (req_payload.queue_class == tcsr_pkg::CLASS_FAST);
               tbl_re      = (req_payload.op == tcsr_pkg::OP_ENQUEUE);
               limit_in    = req_limit;
               n_in        = '0;
               rescue_in   = 1'b0;
               rescued_in  = '0;
            end
         end
         tcsr_pkg::S_ENQ: begin
            if (enq_status == tcsr_pkg::ST_ACCEPTED) begin
               q_we   = 1'b1;
               q_addr = enq_id_ff;
               q_data = 1'b1;
               if (enq_fast_ff) begin
                  fram_we  = 1'b1;
                  ftail_in = ptr_next(ftail_ff);
                  fcnt_in  = fcnt_ff + 1'b1;
               end else begin
                  mram_we  = 1'b1;
                  mtail_in = ptr_next(mtail_ff);
                  mcnt_in  = mcnt_ff + 1'b1;
               end
            end
            o_kind_in   = tcsr_pkg::KIND_STATUS;
            o_status_in = enq_status;
            o_id_in     = '0;
            o_main_in   = 1'b0;
            o_last_in   = 1'b1;
         end
         tcsr_pkg::S_EXP_RD: begin
            mram_re = (mcnt_ff != '0);
         end
         tcsr_pkg::S_EXP_CHK: begin
            // expired head: free the id and start its cooldown
            if (exp_hit) begin
               mhead_in   = ptr_next(mhead_ff);
               mcnt_in    = mcnt_ff - 1'b1;
               q_we       = 1'b1;
               q_addr     = mhead_id;
               cd_we      = 1'b1;
               exp_tot_in = exp_tot_ff + 1'b1;
            end
         end
         tcsr_pkg::S_DECIDE: begin
            streak_in = (fcnt_ff != '0) ? streak_ff + 1'b1 : '0;
         end
         tcsr_pkg::S_FAST_RD: begin
            fram_re = fast_go;
         end
         tcsr_pkg::S_FAST_POP: begin
            fhead_in    = ptr_next(fhead_ff);
            fcnt_in     = fcnt_ff - 1'b1;
            q_we        = 1'b1;
            q_addr      = fram_rdata;
            fast_tot_in = fast_tot_ff + 1'b1;
            bram_we     = 1'b1;
            bram_wdata  = {1'b0, fram_rdata};
            n_in        = n_ff + 1'b1;
         end
         tcsr_pkg::S_RESC_CHK: begin
            rescue_in = 1'b1;
         end
         tcsr_pkg::S_MAIN_RD: begin
            mram_re = main_go;
            if (!main_go && rescue_ff && (rescued_ff != '0)) begin
               streak_in = '0;
            end
         end
         tcsr_pkg::S_MAIN_POP: begin
            mhead_in    = ptr_next(mhead_ff);
            mcnt_in     = mcnt_ff - 1'b1;
            q_we        = 1'b1;
            q_addr      = mhead_id;
            main_tot_in = main_tot_ff + 1'b1;
            bram_we     = 1'b1;
            bram_wdata  = {1'b1, mhead_id};
            n_in        = n_ff + 1'b1;
            rescued_in  = rescued_ff + 1'b1;
         end
         tcsr_pkg::S_FINISH: begin
            tick_in = tick_ff + 1'b1;
            k_in    = '0;
         end
         tcsr_pkg::S_EMIT_RD: begin
            if (n_ff == '0) begin
               o_kind_in   = tcsr_pkg::KIND_NONE;
               o_status_in = tcsr_pkg::ST_ACCEPTED;
               o_id_in     = '0;
               o_main_in   = 1'b0;
               o_last_in   = 1'b1;
            end else begin
               bram_re = 1'b1;
            end
         end
         tcsr_pkg::S_EMIT_LOAD: begin
            o_kind_in   = tcsr_pkg::KIND_EVENT;
            o_status_in = tcsr_pkg::ST_ACCEPTED;
            o_id_in     = tcsr_pkg::EVENT_W'(bram_rdata[ID_BITS-1:0]);
            o_main_in   = bram_rdata[ID_BITS];
            o_last_in   = emit_last;
            k_in        = k_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tcsr_pkg::S_IDLE;
         tick_ff     <= '0;
         streak_ff   <= '0;
         fast_tot_ff <= '0;
         main_tot_ff <= '0;
         exp_tot_ff  <= '0;
         fhead_ff    <= '0;
         ftail_ff    <= '0;
         mhead_ff    <= '0;
         mtail_ff    <= '0;
         fcnt_ff     <= '0;
         mcnt_ff     <= '0;
         n_ff        <= '0;
         k_ff        <= '0;
         rescued_ff  <= '0;
         rescue_ff   <= 1'b0;
         o_last_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         tick_ff     <= tick_in;
         streak_ff   <= streak_in;
         fast_tot_ff <= fast_tot_in;
         main_tot_ff <= main_tot_in;
         exp_tot_ff  <= exp_tot_in;
         fhead_ff    <= fhead_in;
         ftail_ff    <= ftail_in;
         mhead_ff    <= mhead_in;
         mtail_ff    <= mtail_in;
         fcnt_ff     <= fcnt_in;
         mcnt_ff     <= mcnt_in;
         n_ff        <= n_in;
         k_ff        <= k_in;
         rescued_ff  <= rescued_in;
         rescue_ff   <= rescue_in;
         o_last_ff   <= o_last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      limit_ff    <= limit_in;
      enq_id_ff   <= enq_id_in;
      enq_fast_ff <= enq_fast_in;
      o_kind_ff   <= o_kind_in;
      o_status_ff <= o_status_in;
      o_id_ff     <= o_id_in;
      o_main_ff   <= o_main_in;
   end

   // fast queue storage
   tcsr_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_fast_ram (
      .clock      (clock),
      .wr_en      (fram_we),
      .wr_addr    (ftail_ff),
      .wr_data    (enq_id_ff),
      .rd_en      (fram_re),
      .rd_addr    (fhead_ff),
      .rd_data_ff (fram_rdata)
   );

   // main queue storage, id with enqueue tick
   tcsr_ram #(
      .WIDTH (MAIN_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_main_ram (
      .clock      (clock),
      .wr_en      (mram_we),
      .wr_addr    (mtail_ff),
      .wr_data    (mram_wdata),
      .rd_en      (mram_re),
      .rd_addr    (mhead_ff),
      .rd_data_ff (mram_rdata)
   );

   // dispatched ids of the current round, replayed once totals are final
   tcsr_ram #(
      .WIDTH (BUF_W),
      .DEPTH (MAX_BATCH)
   ) u_result_buf (
      .clock      (clock),
      .wr_en      (bram_we),
      .wr_addr    (n_ff[BUF_AW-1:0]),
      .wr_data    (bram_wdata),
      .rd_en      (bram_re),
      .rd_addr    (k_ff[BUF_AW-1:0]),
      .rd_data_ff (bram_rdata)
   );

   // queued bitmap and cooldown deadlines
   tcsr_id_table #(
      .ID_BITS (ID_BITS)
   ) u_id_table (
      .clock       (clock),
      .reset       (reset),
      .busy        (tbl_busy),
      .rd_en       (tbl_re),
      .rd_addr     (tbl_raddr),
      .rd_queued   (tbl_queued),
      .rd_cooldown (tbl_cool),
      .q_we        (q_we),
      .q_addr      (q_addr),
      .q_data      (q_data),
      .cd_we       (cd_we),
      .cd_addr     (cd_addr),
      .cd_data     (cd_data)
   );

   // ports
   assign req_stall = (state_ff != tcsr_pkg::S_IDLE) || tbl_busy;
   assign rsp_valid = (state_ff == tcsr_pkg::S_EMIT_HOLD);

   always_comb begin
      rsp_payload.kind               = o_kind_ff;
      rsp_payload.enqueue_status     = o_status_ff;
      rsp_payload.out_event_id       = o_id_ff;
      rsp_payload.from_main          = o_main_ff;
      rsp_payload.last               = o_last_ff;
      rsp_payload.fast_emitted_total = fast_tot_ff;
      rsp_payload.main_emitted_total = main_tot_ff;
      rsp_payload.main_expired_total = exp_tot_ff;
   end

`ifndef SYNTHESIS
   // no new request while a result is offered
   a_stall_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");

   // queue occupancy never exceeds storage
   a_fcnt_bound: assert property (@(posedge clock) disable iff (reset)
      (fcnt_ff <= CNT_W'(QUEUE_DEPTH)) && (mcnt_ff <= CNT_W'(QUEUE_DEPTH)))
      else $error("queue count overflow");

   // a round never emits past its batch limit
   a_batch_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcsr_pkg::S_FAST_POP || state_ff == tcsr_pkg::S_MAIN_POP)
      |-> (n_ff < limit_ff))
      else $error("batch limit exceeded");

   // replay index stays inside the round
   a_replay_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcsr_pkg::S_EMIT_LOAD) |-> (k_ff < n_ff))
      else $error("result replay past end");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the two-class rescue scheduler: a scoreboard model
// tracks both fifos, the queued map, the cooldown table and the counters, and
// every result is compared field by field under several csr settings and
// several sender and receiver idling mixes
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   localparam int QD     = tcsr_pkg::QUEUE_DEPTH_DEF;
   localparam int N_IDS  = 1 << tcsr_pkg::ID_BITS_DEF;
   localparam int RING   = 128;

   typedef struct {
      logic [tcsr_pkg::EVENT_W-1:0] id;
      logic [tcsr_pkg::WORD_W-1:0]  tick;
   } main_entry_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   tcsr_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_stall;
   tcsr_pkg::rsp_type rsp_payload;
   logic              csr_we;
   logic [tcsr_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [tcsr_pkg::CSR_DATA_W-1:0] csr_wdata;

   // scoreboard model of the scheduler
   logic [tcsr_pkg::INTERVAL_W-1:0] cfg_interval;
   logic [tcsr_pkg::QUOTA_W-1:0]    cfg_quota;
   logic [tcsr_pkg::WORD_W-1:0]     cfg_ttl;
   logic [tcsr_pkg::WORD_W-1:0]     cfg_cooldown;
   logic [tcsr_pkg::WORD_W-1:0]     ticks;
   logic [tcsr_pkg::WORD_W-1:0]     fast_run;
   logic [tcsr_pkg::WORD_W-1:0]     fast_sent, main_sent, main_aged;
   logic [tcsr_pkg::EVENT_W-1:0]    fast_ids[QD];
   int                              fast_hd, fast_n;
   main_entry_type                  main_ents[QD];
   int                              main_hd, main_n;
   logic                            in_queue[N_IDS];
   logic [tcsr_pkg::WORD_W-1:0]     blocked_until[N_IDS];

   // expected results in order, written by the model, read by the checker
   tcsr_pkg::rsp_type exp_ring[RING];
   int      exp_wr, exp_rd;
   int      fails;
   int      gap_pct;
   int      stall_pct;
   int      hold_left;

   two_class_starvation_rescue_scheduler_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // generous fixed limit
   initial begin
      #8000000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic tcsr_pkg::rsp_type event_rsp(input logic [tcsr_pkg::EVENT_W-1:0] id,
                                                   input logic from_main);
      tcsr_pkg::rsp_type t;
      t = '0;
      t.kind = tcsr_pkg::KIND_EVENT;
      t.out_event_id = id;
      t.from_main = from_main;
      return t;
   endfunction

   task automatic take_main(output main_entry_type m);
      m = main_ents[main_hd];
      main_hd = (main_hd + 1) % QD;
      main_n--;
   endtask

   // works out the results of one accepted request and queues them
   task automatic schedule_model(input tcsr_pkg::req_type r);
      tcsr_pkg::rsp_type res[tcsr_pkg::MAX_BATCH_DEF];
      tcsr_pkg::rsp_type t;
      main_entry_type    m;
      logic [tcsr_pkg::EVENT_W-1:0] id;
      int nres;
      int lim;
      int rescued;
      t = '0;
      nres = 0;
      id = r.evt_id;
      if (r.op == tcsr_pkg::OP_ENQUEUE) begin
         t.kind = tcsr_pkg::KIND_STATUS;
         if (in_queue[id]) begin
            t.enqueue_status = tcsr_pkg::ST_DUPLICATE;
         end else if (r.queue_class != tcsr_pkg::CLASS_FAST && blocked_until[id] > ticks) begin
            t.enqueue_status = tcsr_pkg::ST_COOLDOWN;
         end else if (r.queue_class == tcsr_pkg::CLASS_FAST) begin
            if (fast_n >= QD) t.enqueue_status = tcsr_pkg::ST_FULL;
            else begin
               fast_ids[(fast_hd + fast_n) % QD] = id;
               fast_n++;
               in_queue[id] = 1'b1;
            end
         end else begin
            if (main_n >= QD) t.enqueue_status = tcsr_pkg::ST_FULL;
            else begin
               m.id = id;
               m.tick = ticks;
               main_ents[(main_hd + main_n) % QD] = m;
               main_n++;
               in_queue[id] = 1'b1;
            end
         end
         res[nres] = t;
         nres++;
      end else begin
         lim = (r.batch_max > tcsr_pkg::MAX_BATCH_DEF) ? tcsr_pkg::MAX_BATCH_DEF
                                                      : int'(r.batch_max);
         // aging of stale main entries at the head
         while (main_n > 0 &&
                tcsr_pkg::WORD_W'(ticks - main_ents[main_hd].tick) > cfg_ttl) begin
            take_main(m);
            in_queue[m.id] = 1'b0;
            blocked_until[m.id] = ticks + cfg_cooldown;
            main_aged++;
         end
         if (fast_n > 0) begin
            while (fast_n > 0 && nres < lim) begin
               id = fast_ids[fast_hd];
               fast_hd = (fast_hd + 1) % QD;
               fast_n--;
               in_queue[id] = 1'b0;
               fast_sent++;
               res[nres] = event_rsp(id, 1'b0);
               nres++;
            end
            fast_run++;
            // starvation rescue of main entries
            if (fast_run >= tcsr_pkg::WORD_W'(cfg_interval) && main_n > 0) begin
               rescued = 0;
               while (main_n > 0 && rescued < cfg_quota && nres < lim) begin
                  take_main(m);
                  in_queue[m.id] = 1'b0;
                  main_sent++;
                  rescued++;
                  res[nres] = event_rsp(m.id, 1'b1);
                  nres++;
               end
               if (rescued > 0) fast_run = '0;
            end
         end else begin
            fast_run = '0;
            while (main_n > 0 && nres < lim) begin
               take_main(m);
               in_queue[m.id] = 1'b0;
               main_sent++;
               res[nres] = event_rsp(m.id, 1'b1);
               nres++;
            end
         end
         ticks++;
         if (nres == 0) begin
            t.kind = tcsr_pkg::KIND_NONE;
            res[nres] = t;
            nres++;
         end
      end
      // every result carries the counters as they stand after the request
      for (int k = 0; k < nres; k++) begin
         res[k].last = (k == nres - 1);
         res[k].fast_emitted_total = fast_sent;
         res[k].main_emitted_total = main_sent;
         res[k].main_expired_total = main_aged;
         exp_ring[exp_wr % RING] = res[k];
         exp_wr++;
      end
   endtask

   // one request on the req channel, with random sender idling beforehand
   task automatic send_req(input logic op, input logic [tcsr_pkg::EVENT_W-1:0] id,
                           input logic qclass, input logic [tcsr_pkg::MAXEV_W-1:0] maxev);
      tcsr_pkg::req_type r;
      r.op = op;
      r.evt_id = id;
      r.queue_class = qclass;
      r.batch_max = maxev;
      while ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      schedule_model(r);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // sender pause until every expected result has come
   task automatic wait_drained();
      stop_sending();
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(input logic [tcsr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tcsr_pkg::CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_config(input logic [tcsr_pkg::INTERVAL_W-1:0] interval,
                             input logic [tcsr_pkg::QUOTA_W-1:0] quota,
                             input logic [tcsr_pkg::WORD_W-1:0] ttl,
                             input logic [tcsr_pkg::WORD_W-1:0] cooldown);
      wait_drained();
      csr_write(tcsr_pkg::CSR_RESCUE_INTERVAL, tcsr_pkg::CSR_DATA_W'(interval));
      csr_write(tcsr_pkg::CSR_RESCUE_QUOTA, tcsr_pkg::CSR_DATA_W'(quota));
      csr_write(tcsr_pkg::CSR_MAIN_TTL, ttl);
      csr_write(tcsr_pkg::CSR_COOLDOWN_TICKS, cooldown);
      cfg_interval = interval;
      cfg_quota    = quota;
      cfg_ttl      = ttl;
      cfg_cooldown = cooldown;
   endtask

   // duplicates, cooldown, rescue, zero and oversized batches, id extremes
   task automatic test_directed();
      set_config(16'd1, 7'd1, 32'd2, 32'd5);
      send_req(tcsr_pkg::OP_SCHEDULE, 10'd0, 1'b0, 7'd0);       // empty round
      send_req(tcsr_pkg::OP_ENQUEUE, 10'd0, 1'b0, 7'd0);
      send_req(tcsr_pkg::OP_ENQUEUE, 10'd1023, 1'b1, 7'd127);
      send_req(tcsr_pkg::OP_ENQUEUE, 10'd0, 1'b1, 7'd0);        // duplicate across classes
      send_req(tcsr_pkg::OP_ENQUEUE, 10'd1023, 1'b1, 7'd0);     // duplicate same class
      send_req(tcsr_pkg::OP_SCHEDULE, 10'd1023, 1'b1, 7'd0);    // zero batch, fast waiting
      send_req(tcsr_pkg::OP_SCHEDULE, 10'd0, 1'b0, 7'd127);     // oversized batch, rescue
      send_req(tcsr_pkg::OP_ENQUEUE, 10'd5, 1'b0, 7'd0);
      send_req(tcsr_pkg::OP_SCHEDULE, 10'd0, 1'b0, 7'd0);
      send_req(tcsr_pkg::OP_SCHEDULE, 10'd0, 1'b0, 7'd0);
      send_req(tcsr_pkg::OP_SCHEDULE, 10'd0, 1'b0, 7'd0);
      send_req(tcsr_pkg::OP_SCHEDULE, 10'd0, 1'b0, 7'd0);       // main entry ages out
      send_req(tcsr_pkg::OP_ENQUEUE, 10'd5, 1'b0, 7'd0);        // refused, cooling down
      send_req(tcsr_pkg::OP_ENQUEUE, 10'd5, 1'b1, 7'd0);        // fast ignores cooldown
      send_req(tcsr_pkg::OP_ENQUEUE, 10'd6, 1'b1, 7'd0);
      send_req(tcsr_pkg::OP_ENQUEUE, 10'd7, 1'b0, 7'd0);
      send_req(tcsr_pkg::OP_SCHEDULE, 10'd0, 1'b0, 7'd1);       // batch too small to rescue
      send_req(tcsr_pkg::OP_SCHEDULE, 10'd0, 1'b0, 7'd64);
      send_req(tcsr_pkg::OP_SCHEDULE, 10'd0, 1'b0, 7'd64);
   endtask

   // receiver holds off long while the sender keeps offering requests
   task automatic test_backpressure();
      set_config(16'd2, 7'd3, 32'd50, 32'd10);
      hold_left = 600;
      for (int i = 0; i < 20; i++)
         send_req(tcsr_pkg::OP_ENQUEUE, tcsr_pkg::EVENT_W'($urandom_range(1023)), i[0], 7'd0);
      send_req(tcsr_pkg::OP_SCHEDULE, 10'd0, 1'b0, 7'd64);
   endtask

   // random mixes across settings and idling phases
   task automatic test_random();
      logic [tcsr_pkg::INTERVAL_W-1:0] ivals[4];
      logic [tcsr_pkg::QUOTA_W-1:0]    qvals[4];
      logic [tcsr_pkg::WORD_W-1:0]     tvals[4];
      logic [tcsr_pkg::WORD_W-1:0]     cvals[4];
      int gaps[4];
      int stalls[4];
      int x;
      ivals = '{16'd0, 16'd1, 16'd3, 16'd65535};
      qvals = '{7'd0, 7'd1, 7'd3, 7'd64};
      tvals = '{32'd0, 32'd4, 32'd25, 32'hFFFF_FFFF};
      cvals = '{32'd0, 32'd6, 32'hFFFF_FFFF, 32'd30};
      gaps   = '{0, 52, 0, 36};
      stalls = '{0, 0, 52, 36};
      for (int p = 0; p < 4; p++) begin
         set_config(ivals[$urandom_range(3)], qvals[$urandom_range(3)],
                    tvals[$urandom_range(3)], cvals[$urandom_range(3)]);
         gap_pct = gaps[p];
         stall_pct = stalls[p];
         for (int i = 0; i < 52; i++) begin
            x = $urandom_range(99);
            if (x < 58)
               send_req(tcsr_pkg::OP_ENQUEUE,
                        ($urandom_range(3) == 0) ? tcsr_pkg::EVENT_W'($urandom_range(1023))
                                                 : tcsr_pkg::EVENT_W'($urandom_range(40)),
                        1'($urandom_range(1)), 7'($urandom_range(127)));
            else
               send_req(tcsr_pkg::OP_SCHEDULE, tcsr_pkg::EVENT_W'($urandom_range(1023)),
                        1'($urandom_range(1)),
                        ($urandom_range(4) == 0) ? 7'($urandom_range(127))
                                                 : 7'($urandom_range(8)));
         end
      end
      gap_pct = 0;
      stall_pct = 0;
   endtask

   // receiver: random stalls plus counted long hold-offs
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic check_field(input string name, input logic [tcsr_pkg::WORD_W-1:0] exp_v,
                              input logic [tcsr_pkg::WORD_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
         fails++;
      end
   endtask

   // result checker against the oldest outstanding expectation
   initial begin
      tcsr_pkg::rsp_type e;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (exp_wr == exp_rd) begin
               $error("unexpected result kind %0d", rsp_payload.kind);
               fails++;
            end else begin
               e = exp_ring[exp_rd % RING];
               exp_rd++;
               check_field("kind", e.kind, rsp_payload.kind);
               check_field("enqueue_status", e.enqueue_status, rsp_payload.enqueue_status);
               check_field("out_event_id", e.out_event_id, rsp_payload.out_event_id);
               check_field("from_main", e.from_main, rsp_payload.from_main);
               check_field("last", e.last, rsp_payload.last);
               check_field("fast_emitted_total", e.fast_emitted_total,
                           rsp_payload.fast_emitted_total);
               check_field("main_emitted_total", e.main_emitted_total,
                           rsp_payload.main_emitted_total);
               check_field("main_expired_total", e.main_expired_total,
                           rsp_payload.main_expired_total);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      fails = 0;
      gap_pct = 0;
      stall_pct = 0;
      hold_left = 0;
      exp_wr = 0;
      exp_rd = 0;
      fast_hd = 0;
      fast_n = 0;
      main_hd = 0;
      main_n = 0;
      cfg_interval = tcsr_pkg::RESCUE_INTERVAL_RST;
      cfg_quota = tcsr_pkg::RESCUE_QUOTA_RST;
      cfg_ttl = tcsr_pkg::MAIN_TTL_RST;
      cfg_cooldown = tcsr_pkg::COOLDOWN_TICKS_RST;
      ticks = '0;
      fast_run = '0;
      fast_sent = '0;
      main_sent = '0;
      main_aged = '0;
      foreach (in_queue[i]) begin
         in_queue[i] = 1'b0;
         blocked_until[i] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings first, then the rest
      send_req(tcsr_pkg::OP_ENQUEUE, 10'd9, 1'b0, 7'd0);
      send_req(tcsr_pkg::OP_SCHEDULE, 10'd0, 1'b0, 7'd3);
      test_directed();
      test_backpressure();
      test_random();

      wait_drained();
      repeat (50) @(posedge clock);
      if (fails == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
